[rtl/core/pst_pkg.sv]
// Shared types and constants for the perspective span texel stepper.
// Depends on nothing; imported by the controller, datapath and top level.
package pst_pkg;

    localparam int NUM_PARAMS = 14;
    localparam int SEG_LEN    = 8;

    // Polygon parameter indexes
    typedef enum logic [3:0] {
        P_SDIVZ = 4'd0, P_TDIVZ = 4'd1, P_ZI = 4'd2,
        P_SDU = 4'd3, P_SDV = 4'd4, P_TDU = 4'd5, P_TDV = 4'd6,
        P_ZU = 4'd7, P_ZV = 4'd8, P_SBIAS = 4'd9, P_TBIAS = 4'd10,
        P_SLIM = 4'd11, P_TLIM = 4'd12, P_PITCH = 4'd13
    } t_param;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,      // write one polygon parameter
        OP_INIT0,     // base = y*pitch + x; start gradient products
        OP_INIT1,     // second gradient products
        OP_INIT2,     // final gradient sums
        OP_ADVANCE,   // step s/z, t/z, 1/z to segment end (by seg_m)
        OP_DIV_S,     // start divide s/z<<8 by zi
        OP_DIV_T,     // start divide t/z<<8 by zi
        OP_STEP_S,    // start divide of s delta by m (last segment)
        OP_STEP_T,
        OP_SHIFT,     // inner segment: steps by shift of 3
        OP_ROW,       // last segment: texel row product only, steps kept
        OP_EMIT,      // emit one pixel and step s, t
        OP_SEGEND     // s1 = snext, t1 = tnext
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       first;   // quotient belongs to the span start
        logic [3:0] seg_m;   // advance amount
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic out_full;
    } t_sts;

    function automatic logic [31:0] asr32(input logic [31:0] x, input int n);
        asr32 = 32'($signed(x) >>> n);
    endfunction

    // Signed clamp: above hi gives hi, below lo gives lo
    function automatic logic [31:0] clampv(input logic [31:0] v, input logic [31:0] hi,
                                           input logic [31:0] lo);
        if ($signed(v) > $signed(hi))      clampv = hi;
        else if ($signed(v) < $signed(lo)) clampv = lo;
        else                               clampv = v;
    endfunction

endpackage

[rtl/core/pst_div.sv]
// Iterative signed 32-bit divider, one quotient bit per cycle.
// Depends on nothing; used by the datapath for perspective and step divides.
module pst_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_busy,
    output logic [31:0] o_quot
);
    logic [31:0] r_rem, r_q, r_den;
    logic [5:0]  r_cnt;
    logic        r_neg;
    logic [32:0] w_trial;

    assign w_trial = {r_rem, r_q[31]} - {1'b0, r_den};
    assign o_busy  = (r_cnt != 6'd0);
    assign o_quot  = r_neg ? (32'd0 - r_q) : r_q;

    // Restoring division on magnitudes, sign applied at the end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 6'd0;
        end else if (i_start) begin
            r_rem <= 32'd0;
            r_q   <= i_num[31] ? 32'd0 - i_num : i_num;
            r_den <= i_den[31] ? 32'd0 - i_den : i_den;
            r_neg <= i_num[31] ^ i_den[31];
            r_cnt <= 6'd32;
        end else if (r_cnt != 6'd0) begin
            if (!w_trial[32]) begin
                r_rem <= w_trial[31:0];
                r_q   <= {r_q[30:0], 1'b1};
            end else begin
                r_rem <= {r_rem[30:0], r_q[31]};
                r_q   <= {r_q[30:0], 1'b0};
            end
            r_cnt <= r_cnt - 6'd1;
        end
    end
endmodule

[rtl/core/pst_datapath.sv]
// Datapath: parameter file, interpolants, divider and output register.
// Depends on pst_pkg and pst_div.
module pst_datapath
    import pst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [12:0] i_screen_pitch,
    input  logic [3:0]  i_param_index,
    input  logic [31:0] i_param_value,
    input  logic [11:0] i_span_x,
    input  logic [11:0] i_span_y,
    input  logic        i_last,
    input  logic        i_out_stall,
    output t_sts        o_sts,
    output logic        o_valid,
    output logic [23:0] o_screen_offset,
    output logic [23:0] o_texel_offset,
    output logic        o_last_pixel
);
    typedef enum logic [1:0] {PK_SN, PK_TN, PK_SS, PK_TS} t_pend;

    logic [31:0] r_p [NUM_PARAMS];
    logic [31:0] r_sdz, r_tdz, r_zi, r_s1, r_t1, r_sn, r_tn, r_ss, r_ts;
    logic [31:0] r_m1, r_m2, r_m3;
    logic [23:0] r_base;
    logic [11:0] r_x;
    logic        r_first, r_pend, r_valid;
    t_pend       r_pend_kind;
    logic [31:0] w_num, w_den, w_quot, w_pv;
    logic [31:0] w_zi_init, w_zi_adv;
    logic        w_start, w_busy;
    logic [31:0] w_tex;

    assign w_pv = (w_quot << 8);
    assign w_tex = asr32(r_s1, 16) + r_m1;
    assign w_zi_init = r_zi + r_m3;
    assign w_zi_adv  = r_zi + r_p[P_ZU] * {28'd0, i_cmd.seg_m};

    pst_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_num(w_num), .i_den(w_den), .o_busy(w_busy), .o_quot(w_quot)
    );

    // Select divider operands per command
    always_comb begin
        w_start = 1'b0;
        w_num   = r_sdz << 8;
        w_den   = r_zi;
        case (i_cmd.op)
            OP_DIV_S:  begin w_start = 1'b1; w_num = r_sdz << 8; end
            OP_DIV_T:  begin w_start = 1'b1; w_num = r_tdz << 8; end
            OP_STEP_S: begin w_start = 1'b1; w_num = r_sn - r_s1;
                             w_den = {28'd0, i_cmd.seg_m}; end
            OP_STEP_T: begin w_start = 1'b1; w_num = r_tn - r_t1;
                             w_den = {28'd0, i_cmd.seg_m}; end
            default: ;
        endcase
    end

    assign o_sts.div_busy = w_busy || r_pend;
    assign o_sts.out_full = r_valid && i_out_stall;
    assign o_valid = r_valid;

    // Parameter file, interpolants and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PARAMS; i++) r_p[i] <= 32'd0;
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            // Raise valid on a new pixel, drop it once the transfer completes
            if (i_cmd.op == OP_EMIT)          r_valid <= 1'b1;
            else if (r_valid && !i_out_stall) r_valid <= 1'b0;
            // Retire a finished divide into its destination
            if (r_pend && !w_busy) begin
                r_pend <= 1'b0;
                case (r_pend_kind)
                    PK_SN: r_sn <= clampv(w_pv + r_p[P_SBIAS], r_p[P_SLIM],
                                          r_first ? 32'd0 : 32'd8);
                    PK_TN: r_tn <= clampv(w_pv + r_p[P_TBIAS], r_p[P_TLIM],
                                          r_first ? 32'd0 : 32'd8);
                    PK_SS: r_ss <= w_quot;
                    default: r_ts <= w_quot;
                endcase
                if (r_first && r_pend_kind == PK_SN)
                    r_s1 <= clampv(w_pv + r_p[P_SBIAS], r_p[P_SLIM], 32'd0);
                if (r_first && r_pend_kind == PK_TN)
                    r_t1 <= clampv(w_pv + r_p[P_TBIAS], r_p[P_TLIM], 32'd0);
            end
            case (i_cmd.op)
                OP_LOAD: if (i_param_index < 4'(NUM_PARAMS))
                    r_p[i_param_index] <= i_param_value;
                OP_INIT0: begin
                    r_x  <= i_span_x;
                    r_base <= 24'({12'd0, i_span_y} * {11'd0, i_screen_pitch}
                                  + {13'd0, i_span_x});
                    r_m1 <= {20'd0, i_span_y} * r_p[P_SDV];
                    r_m2 <= {20'd0, i_span_y} * r_p[P_TDV];
                    r_m3 <= {20'd0, i_span_y} * r_p[P_ZV];
                end
                OP_INIT1: begin
                    r_sdz <= r_p[P_SDIVZ] + r_m1;
                    r_tdz <= r_p[P_TDIVZ] + r_m2;
                    r_zi  <= r_p[P_ZI] + r_m3;
                    r_m1 <= {20'd0, r_x} * r_p[P_SDU];
                    r_m2 <= {20'd0, r_x} * r_p[P_TDU];
                    r_m3 <= {20'd0, r_x} * r_p[P_ZU];
                end
                // Substitute 1 for a zero 1/z; later steps build on it
                OP_INIT2: begin
                    r_sdz <= r_sdz + r_m1;
                    r_tdz <= r_tdz + r_m2;
                    r_zi  <= (w_zi_init == 32'd0) ? 32'd1 : w_zi_init;
                    r_first <= 1'b1;
                end
                OP_ADVANCE: begin
                    r_sdz <= r_sdz + r_p[P_SDU] * {28'd0, i_cmd.seg_m};
                    r_tdz <= r_tdz + r_p[P_TDU] * {28'd0, i_cmd.seg_m};
                    r_zi  <= (w_zi_adv == 32'd0) ? 32'd1 : w_zi_adv;
                    r_first <= 1'b0;
                end
                OP_DIV_S:  begin r_pend <= 1'b1; r_pend_kind <= PK_SN; end
                OP_DIV_T:  begin r_pend <= 1'b1; r_pend_kind <= PK_TN; end
                OP_STEP_S: begin r_pend <= 1'b1; r_pend_kind <= PK_SS; end
                OP_STEP_T: begin r_pend <= 1'b1; r_pend_kind <= PK_TS; end
                OP_SHIFT: begin
                    r_ss <= asr32(r_sn - r_s1, 3);
                    r_ts <= asr32(r_tn - r_t1, 3);
                    r_m1 <= asr32(r_t1, 16) * r_p[P_PITCH];
                end
                OP_ROW: r_m1 <= asr32(r_t1, 16) * r_p[P_PITCH];
                OP_EMIT: begin
                    o_screen_offset <= r_base;
                    o_texel_offset  <= w_tex[23:0];
                    o_last_pixel    <= i_last;
                    r_base  <= r_base + 24'd1;
                    r_s1 <= r_s1 + r_ss;
                    r_t1 <= r_t1 + r_ts;
                    r_m1 <= asr32(r_t1 + r_ts, 16) * r_p[P_PITCH];
                end
                OP_SEGEND: begin
                    r_s1 <= r_sn;
                    r_t1 <= r_tn;
                    r_m1 <= asr32(r_tn, 16) * r_p[P_PITCH];
                end
                default: ;
            endcase
        end
    end
endmodule

[rtl/core/pst_ctrl.sv]
// Controller: sequences loads, span set-up, segment divides and pixel emission.
// Depends on pst_pkg.
module pst_ctrl
    import pst_pkg::*;
#(
    parameter int MAX_SPAN_LEN = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_kind,
    input  logic [6:0] i_span_length,
    input  t_sts       i_sts,
    output logic       o_stall,
    output logic       o_last,
    output t_cmd       o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_I1, S_I2, S_DS, S_DT, S_WAIT, S_SEG, S_ADV, S_SS, S_ST,
        S_SWAIT, S_SHIFT, S_EMIT, S_END
    } t_state;

    t_state     r_state;
    logic [6:0] r_left, r_k;
    logic [3:0] r_sc;
    logic       r_first;
    logic [6:0] w_n;
    logic       w_acc;

    assign w_n   = (i_span_length > 7'(MAX_SPAN_LEN)) ? 7'(MAX_SPAN_LEN) : i_span_length;
    assign o_stall = (r_state != S_IDLE);
    assign w_acc = i_valid && (r_state == S_IDLE);
    assign o_last = (r_left == 7'd0) && (r_k == 7'd1);

    // Issue commands combinationally from state
    always_comb begin
        o_cmd = '{op: OP_NONE, first: r_first, seg_m: r_sc - 4'd1};
        case (r_state)
            S_IDLE: if (w_acc) o_cmd.op = i_kind ? OP_LOAD :
                                 (w_n != 7'd0 ? OP_INIT0 : OP_NONE);
            S_I1:  o_cmd.op = OP_INIT1;
            S_I2:  o_cmd.op = OP_INIT2;
            S_DS:  o_cmd.op = OP_DIV_S;
            S_DT:  if (!i_sts.div_busy) o_cmd.op = OP_DIV_T;
            S_ADV: begin
                o_cmd.op = OP_ADVANCE;
                if (r_left != 7'd0) o_cmd.seg_m = 4'(SEG_LEN);
            end
            S_SS:  o_cmd.op = OP_STEP_S;
            S_ST:  if (!i_sts.div_busy) o_cmd.op = OP_STEP_T;
            // Keep the divided steps of a last segment
            S_SHIFT: o_cmd.op = (r_left == 7'd0 && r_sc > 4'd1) ? OP_ROW : OP_SHIFT;
            S_EMIT: if (!i_sts.out_full) o_cmd.op = OP_EMIT;
            S_END: o_cmd.op = OP_SEGEND;
            default: ;
        endcase
    end

    // State and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_left  <= 7'd0;
            r_k     <= 7'd0;
            r_sc    <= 4'd0;
            r_first <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: if (w_acc && !i_kind && w_n != 7'd0) begin
                    r_left <= w_n;
                    r_first <= 1'b1;
                    r_state <= S_I1;
                end
                S_I1: r_state <= S_I2;
                S_I2: r_state <= S_DS;
                S_DS: r_state <= S_DT;
                S_DT: if (!i_sts.div_busy) r_state <= S_WAIT;
                S_WAIT: if (!i_sts.div_busy) begin
                    if (r_first) begin
                        r_first <= 1'b0;
                        r_state <= S_SEG;
                    end else if (r_left == 7'd0) begin
                        r_state <= (r_sc > 4'd1) ? S_SS : S_SHIFT;
                    end else begin
                        r_state <= S_SHIFT;
                    end
                end
                S_SEG: begin
                    r_sc   <= (r_left >= 7'(SEG_LEN)) ? 4'(SEG_LEN) : r_left[3:0];
                    r_left <= (r_left >= 7'(SEG_LEN)) ? r_left - 7'(SEG_LEN) : 7'd0;
                    r_k    <= (r_left >= 7'(SEG_LEN)) ? 7'(SEG_LEN) : r_left;
                    r_state <= S_ADV;
                end
                S_ADV: r_state <= S_DS;
                S_SS: r_state <= S_ST;
                S_ST: if (!i_sts.div_busy) r_state <= S_SWAIT;
                S_SWAIT: if (!i_sts.div_busy) r_state <= S_SHIFT;
                S_SHIFT: r_state <= S_EMIT;
                S_EMIT: if (!i_sts.out_full) begin
                    r_k <= r_k - 7'd1;
                    if (r_k == 7'd1) r_state <= S_END;
                end
                S_END: r_state <= (r_left == 7'd0) ? S_IDLE : S_SEG;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[rtl/core/perspective_span_texel_stepper.sv]
// Top level of the perspective span texel stepper.
// Depends on pst_pkg, pst_ctrl, pst_datapath and pst_div.
//
//  channel | direction | handshake        | payload
//  input   | in        | i_valid/o_stall  | kind, param_index, param_value, span_x/y/length
//  output  | out       | o_valid/i_stall  | screen_offset, texel_offset, last_pixel
//  config  | in        | i_cfg_we         | screen_pitch (13 bits)
//
// A load is taken while idle and leaves the input free for the next item. A span runs its
// set-up, then its two start divides on the shared divider; each segment then advances
// to its end, divides there and emits its pixels, and a last segment of more than one
// pixel adds its step divides before emitting.
// Reset is synchronous; pitch returns to 320 and the parameters to zero.
// An output stall holds the pixel loop; the input is stalled while a span runs.
module perspective_span_texel_stepper
    import pst_pkg::*;
#(
    parameter int MAX_SPAN_LEN = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [12:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [3:0]  i_param_index,
    input  logic [31:0] i_param_value,
    input  logic [11:0] i_span_x,
    input  logic [11:0] i_span_y,
    input  logic [6:0]  i_span_length,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [23:0] o_screen_offset,
    output logic [23:0] o_texel_offset,
    output logic        o_last_pixel
);
    logic [12:0] r_pitch;
    t_cmd        w_cmd;
    t_sts        w_sts;
    logic        w_last;

    // Hold the screen pitch register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_pitch <= 13'd320;
        else if (i_cfg_we) r_pitch <= i_cfg_data;
    end

    pst_ctrl #(.MAX_SPAN_LEN(MAX_SPAN_LEN)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_kind(i_kind),
        .i_span_length(i_span_length), .i_sts(w_sts), .o_stall(o_stall),
        .o_last(w_last), .o_cmd(w_cmd)
    );

    pst_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_screen_pitch(r_pitch),
        .i_param_index(i_param_index), .i_param_value(i_param_value),
        .i_span_x(i_span_x), .i_span_y(i_span_y), .i_last(w_last),
        .i_out_stall(i_stall), .o_sts(w_sts), .o_valid(o_valid),
        .o_screen_offset(o_screen_offset), .o_texel_offset(o_texel_offset),
        .o_last_pixel(o_last_pixel)
    );

    // A stalled result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_texel_offset))
        else $error("result dropped under stall");
    // No load or span start while busy
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> w_cmd.op != OP_LOAD && w_cmd.op != OP_INIT0)
        else $error("item started while busy");
endmodule

[test/pst_span_checker.sv]
// Span checker for the perspective span texel stepper: watches both channels,
// predicts every pixel transfer and compares. Depends on pst_pkg.
`timescale 1ns / 1ps

module pst_span_checker
    import pst_pkg::*;
#(
    parameter int MAX_SPAN_LEN = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [12:0] i_cfg_data,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  logic        i_kind,
    input  logic [3:0]  i_param_index,
    input  logic [31:0] i_param_value,
    input  logic [11:0] i_span_x,
    input  logic [11:0] i_span_y,
    input  logic [6:0]  i_span_length,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [23:0] i_screen_offset,
    input  logic [23:0] i_texel_offset,
    input  logic        i_last_pixel,
    output int          o_failures,
    output int          o_pending
);

    typedef struct packed {
        logic [23:0] screen;
        logic [23:0] texel;
        logic        last;
    } t_pixel;

    logic [31:0] poly [NUM_PARAMS];
    logic [12:0] pitch;
    t_pixel      pixel_queue [$];
    int          failures;

    assign o_failures = failures;
    assign o_pending  = pixel_queue.size();

    function automatic logic [31:0] sdiv(input logic [31:0] a, input logic [31:0] b);
        longint q;
        q = longint'($signed(a)) / longint'($signed(b));
        return q[31:0];
    endfunction

    function automatic logic [31:0] proj(input logic [31:0] num, input logic [31:0] zi,
                                         input logic [31:0] bias);
        logic [31:0] q;
        q = sdiv(num << 8, zi);
        return (q << 8) + bias;
    endfunction

    function automatic logic [31:0] limit(input logic [31:0] v, input logic [31:0] hi,
                                          input logic [31:0] lo);
        if ($signed(v) > $signed(hi)) return hi;
        if ($signed(v) < $signed(lo)) return lo;
        return v;
    endfunction

    function automatic logic [31:0] sra(input logic [31:0] v, input int n);
        return 32'($signed(v) >>> n);
    endfunction

    // Walk the span in 8-pixel segments and queue one pixel per column
    task automatic predict_span(input logic [11:0] x, input logic [11:0] y,
                                input logic [6:0] len);
        logic [31:0] n, cnt, sz, tz, zi, s, t, sn, tn, ss, ts, base, k, sc, m, tex;
        t_pixel px;
        ss = 0; ts = 0; k = 0;
        n = (len > MAX_SPAN_LEN) ? MAX_SPAN_LEN : len;
        if (n == 0) return;
        base = {20'd0, y} * {19'd0, pitch} + {20'd0, x};
        sz = poly[P_SDIVZ] + {20'd0, y} * poly[P_SDV] + {20'd0, x} * poly[P_SDU];
        tz = poly[P_TDIVZ] + {20'd0, y} * poly[P_TDV] + {20'd0, x} * poly[P_TDU];
        zi = poly[P_ZI] + {20'd0, y} * poly[P_ZV] + {20'd0, x} * poly[P_ZU];
        if (zi == 0) zi = 1;
        s = limit(proj(sz, zi, poly[P_SBIAS]), poly[P_SLIM], 0);
        t = limit(proj(tz, zi, poly[P_TBIAS]), poly[P_TLIM], 0);
        cnt = n;
        while (cnt > 0) begin
            sc = (cnt >= SEG_LEN) ? SEG_LEN : cnt;
            cnt -= sc;
            m = (cnt != 0) ? SEG_LEN : sc - 1;
            sz += poly[P_SDU] * m;
            tz += poly[P_TDU] * m;
            zi += poly[P_ZU] * m;
            if (zi == 0) zi = 1;
            sn = limit(proj(sz, zi, poly[P_SBIAS]), poly[P_SLIM], 8);
            tn = limit(proj(tz, zi, poly[P_TBIAS]), poly[P_TLIM], 8);
            if (cnt != 0) begin
                ss = sra(sn - s, 3);
                ts = sra(tn - t, 3);
            end else if (sc > 1) begin
                ss = sdiv(sn - s, m);
                ts = sdiv(tn - t, m);
            end
            for (int j = 0; j < sc; j++) begin
                tex = sra(s, 16) + sra(t, 16) * poly[P_PITCH];
                px.screen = 24'(base + k);
                px.texel  = tex[23:0];
                px.last   = (k == n - 1);
                pixel_queue.push_back(px);
                s += ss;
                t += ts;
                k++;
            end
            s = sn;
            t = tn;
        end
    endtask

    // Track configuration and input transfers, compare output transfers
    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PARAMS; i++) poly[i] <= '0;
            pitch <= 13'd320;
            pixel_queue.delete();
            failures <= 0;
        end else begin
            if (i_cfg_we) pitch <= i_cfg_data;
            if (i_valid && !i_stall_in) begin
                if (i_kind) begin
                    if (i_param_index < NUM_PARAMS) poly[i_param_index] <= i_param_value;
                end else begin
                    predict_span(i_span_x, i_span_y, i_span_length);
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (pixel_queue.size() == 0) begin
                    failures <= failures + 1;
                    if (failures < 10)
                        $display("unexpected pixel: screen %h texel %h last %b",
                                 i_screen_offset, i_texel_offset, i_last_pixel);
                end else begin
                    want = pixel_queue.pop_front();
                    if (want !== {i_screen_offset, i_texel_offset, i_last_pixel}) begin
                        failures <= failures + 1;
                        if (failures < 10)
                            $display("pixel mismatch: expected %h/%h/%b got %h/%h/%b",
                                     want.screen, want.texel, want.last,
                                     i_screen_offset, i_texel_offset, i_last_pixel);
                    end
                end
            end
        end
    end

endmodule

[test/testbench.sv]
// Stimulus and verdict for the perspective span texel stepper.
// Depends on pst_pkg, the block and pst_span_checker.
`timescale 1ns / 1ps

module testbench;
    import pst_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [12:0] cfg_data = '0;
    logic        in_valid = 0;
    logic        in_stall;
    logic        kind = 0;
    logic [3:0]  param_index = '0;
    logic [31:0] param_value = '0;
    logic [11:0] span_x = '0, span_y = '0;
    logic [6:0]  span_length = 7'd1;
    logic        out_valid;
    logic        out_stall = 0;
    logic [23:0] screen_offset, texel_offset;
    logic        last_pixel;
    int          failures, pending;
    int          idle_pct = 0, stall_pct = 0;
    bit          hold_off = 0;

    always #5 clk = ~clk;

    perspective_span_texel_stepper dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_stall(in_stall), .i_kind(kind),
        .i_param_index(param_index), .i_param_value(param_value),
        .i_span_x(span_x), .i_span_y(span_y), .i_span_length(span_length),
        .o_valid(out_valid), .i_stall(out_stall), .o_screen_offset(screen_offset),
        .o_texel_offset(texel_offset), .o_last_pixel(last_pixel)
    );

    pst_span_checker chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .i_stall_in(in_stall), .i_kind(kind),
        .i_param_index(param_index), .i_param_value(param_value),
        .i_span_x(span_x), .i_span_y(span_y), .i_span_length(span_length),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_screen_offset(screen_offset), .i_texel_offset(texel_offset),
        .i_last_pixel(last_pixel), .o_failures(failures), .o_pending(pending)
    );

    // Receiver stall, with a forced hold-off when requested
    always @(posedge clk)
        out_stall <= hold_off || ($urandom_range(99) < stall_pct);

    // Release the forced hold-off after a long stretch
    initial begin
        wait (hold_off);
        repeat (400) @(posedge clk);
        hold_off = 0;
    end

    // Offer one item, idling at random first, and hold it until the transfer
    task automatic send(input logic k, input logic [3:0] idx, input logic [31:0] val,
                        input logic [11:0] x, input logic [11:0] y, input logic [6:0] len);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid    <= 1;
        kind        <= k;
        param_index <= idx;
        param_value <= val;
        span_x      <= x;
        span_y      <= y;
        span_length <= len;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic load(input t_param idx, input logic [31:0] val);
        send(1'b1, idx, val, '0, '0, 7'd1);
    endtask

    task automatic span(input logic [11:0] x, input logic [11:0] y, input logic [6:0] len);
        send(1'b0, 4'd0, $urandom, x, y, len);
    endtask

    // Drop valid, drain, then write the pitch while idle
    task automatic set_pitch(input logic [12:0] value);
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0 || in_stall) @(posedge clk);
        repeat (200) @(posedge clk);
        cfg_we   <= 1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    // A plausible polygon: gentle gradients, sane 1/z, small texture
    task automatic load_polygon();
        load(P_SDIVZ, $urandom_range(1 << 24));
        load(P_TDIVZ, $urandom_range(1 << 24));
        load(P_ZI, $urandom_range(1 << 22, 1 << 20));
        load(P_SDU, $urandom_range(4000) - 2000);
        load(P_SDV, $urandom_range(4000) - 2000);
        load(P_TDU, $urandom_range(4000) - 2000);
        load(P_TDV, $urandom_range(4000) - 2000);
        load(P_ZU, $urandom_range(200) - 100);
        load(P_ZV, $urandom_range(200) - 100);
        load(P_SBIAS, $urandom_range(1 << 20));
        load(P_TBIAS, $urandom_range(1 << 20));
        load(P_SLIM, $urandom_range(32'h00FF_FFFF, 32'h0001_0000));
        load(P_TLIM, $urandom_range(32'h00FF_FFFF, 32'h0001_0000));
        load(P_PITCH, $urandom_range(256));
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: zero state and zero 1/z, extremes of coordinates and lengths
        span(12'd0, 12'd0, 7'd1);
        span(12'hFFF, 12'hFFF, 7'd0);
        span(12'hFFF, 12'hFFF, 7'd127);
        load(P_ZI, 32'h8000_0000);
        load(P_SDIVZ, 32'h8000_0000);
        load(P_PITCH, 32'hFFFF_FFFF);
        load(P_SLIM, 32'h7FFF_FFFF);
        load(P_TLIM, 32'h7FFF_FFFF);
        load(P_SBIAS, 32'h8000_0000);
        send(1'b1, 4'd15, 32'hDEAD_BEEF, '0, '0, 7'd1);
        span(12'd5, 12'd3, 7'd9);
        load(P_ZI, 32'hFFFF_FFFF);
        load(P_SDIVZ, 32'h7FFF_FFFF);
        load(P_TDIVZ, 32'h8000_0000);
        span(12'd0, 12'd0, 7'd2);
        span(12'hABC, 12'h543, 7'd64);
        span(12'd1, 12'd1, 7'd65);
        set_pitch(13'd1);
        span(12'hFFF, 12'hFFF, 7'd8);
        set_pitch(13'd4096);
        span(12'hFFF, 12'hFFF, 7'd16);
        set_pitch(13'h1FFF);
        span(12'h800, 12'h7FF, 7'd3);

        // Random: well-formed polygons then spans, some noise loads
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 87; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 87; end
                3: begin idle_pct = 9;  stall_pct = 9;  end
                default: begin idle_pct = 0; stall_pct = 0; end
            endcase
            set_pitch(ph == 4 ? 13'd320 : 13'($urandom_range(4096, 1)));
            if (ph == 4) hold_off = 1;
            load_polygon();
            for (int i = 0; i < 4; i++) begin
                if ($urandom_range(9) == 0)
                    send(1'b1, 4'($urandom), $urandom, '0, '0, 7'd1);
                else
                    span(12'($urandom), 12'($urandom),
                         ($urandom_range(9) == 0) ? 7'($urandom)
                                                  : 7'($urandom_range(20, 1)));
            end
        end
        idle_pct = 0;
        stall_pct = 0;

        in_valid <= 0;
        @(posedge clk);
        while (pending != 0 || in_stall) @(posedge clk);
        repeat (300) @(posedge clk);
        if (failures == 0)
            $display("perspective_span_texel_stepper regression: pass");
        else
            $display("perspective_span_texel_stepper regression: fail");
        $finish;
    end

    initial begin
        #20ms;
        $display("perspective_span_texel_stepper regression: fail");
        $finish;
    end

endmodule
